>>> src/odx_pkg.sv
// Shared types and constants for the Ostrowski digit expansion block.
package odx_pkg;

  localparam int NUM_PLACES    = 50;
  localparam int MAX_QUOTIENTS = 32;
  localparam int NUM_W         = 63;
  localparam int DIGIT_W       = 8;
  localparam int PLACE_AW      = $clog2(NUM_PLACES);
  localparam int DIV_STEP_W    = $clog2(DIGIT_W);
  localparam int QUOT_W        = MAX_QUOTIENTS * DIGIT_W;
  localparam int KIDX_W        = $clog2(MAX_QUOTIENTS) + 1;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

  localparam logic [NUM_W-1:0] VAL_LIMIT = {NUM_W{1'b1}};

  localparam logic [QUOT_W-1:0] QUOT_RESET = {
    64'd72340172838076673, 64'd72340172838076673,
    64'd72340172838076673, 64'd72340172838076672};
  localparam logic [KIDX_W-1:0]   SEQ_LEN_RESET = KIDX_W'(2);
  localparam logic [KIDX_W-2:0]   REP_IDX_RESET = (KIDX_W-1)'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_QWORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QWORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QWORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QWORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REP_IDX = 3'd5;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_RANGE     = 2'd1,
    ERR_OVERFLOW  = 2'd2,
    ERR_ZERO_QUOT = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_INIT,
    T_ONE,
    T_MUL,
    T_ADD
  } tbl_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_DIV,
    B_PUT
  } back_state_t;

  typedef struct packed {
    logic             busy;
    err_t             err;
    logic [NUM_W-1:0] top;
  } tbl_status_t;

  typedef struct packed {
    logic                en;
    logic [PLACE_AW-1:0] addr;
    logic [NUM_W-1:0]    data;
  } place_wr_t;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic             single;
    err_t             code;
  } job_t;

endpackage

>>> src/odx_table.sv
// Configuration registers and the sequential builder of the place-value table.
module odx_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [odx_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [odx_pkg::CFG_DATA_W-1:0]   cfg_data,
  output odx_pkg::tbl_status_t             status,
  output odx_pkg::place_wr_t               place_wr
);

  localparam int KW = odx_pkg::KIDX_W;

  logic [odx_pkg::QUOT_W-1:0]   quots;
  logic [KW-1:0]                seq_len;
  logic [KW-2:0]                rep_idx;
  odx_pkg::tbl_state_t          state, state_next;
  odx_pkg::err_t                err;
  logic [odx_pkg::NUM_W-1:0]    prev, prev2, top;
  logic [odx_pkg::NUM_W+odx_pkg::DIGIT_W-1:0] prod;
  logic [odx_pkg::NUM_W:0]      sum;
  logic [odx_pkg::PLACE_AW-1:0] idx;
  logic [KW-1:0]                k, kk, len;
  logic [KW-2:0]                rep;
  logic [odx_pkg::DIGIT_W-1:0]  a_k, a_one;
  logic                         cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && (cfg_index <= odx_pkg::CFG_REP_IDX);

  always_comb begin
    if (seq_len < KW'(2)) len = KW'(2);
    else if (seq_len > KW'(odx_pkg::MAX_QUOTIENTS)) len = KW'(odx_pkg::MAX_QUOTIENTS);
    else len = seq_len;
    if ({1'b0, rep_idx} >= len) rep = (KW-1)'(len - KW'(1));
    else rep = rep_idx;
    kk    = (k >= len) ? {1'b0, rep} : k;
    a_k   = quots[kk[KW-2:0]*odx_pkg::DIGIT_W +: odx_pkg::DIGIT_W];
    a_one = quots[odx_pkg::DIGIT_W +: odx_pkg::DIGIT_W];
    sum   = {1'b0, prod[odx_pkg::NUM_W-1:0]} + {1'b0, prev2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quots   <= odx_pkg::QUOT_RESET;
      seq_len <= odx_pkg::SEQ_LEN_RESET;
      rep_idx <= odx_pkg::REP_IDX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        odx_pkg::CFG_QWORD_0: quots[0*64 +: 64] <= cfg_data;
        odx_pkg::CFG_QWORD_1: quots[1*64 +: 64] <= cfg_data;
        odx_pkg::CFG_QWORD_2: quots[2*64 +: 64] <= cfg_data;
        odx_pkg::CFG_QWORD_3: quots[3*64 +: 64] <= cfg_data;
        odx_pkg::CFG_SEQ_LEN: seq_len <= cfg_data[KW-1:0];
        odx_pkg::CFG_REP_IDX: rep_idx <= cfg_data[KW-2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= odx_pkg::T_INIT;
    else state <= state_next;
  end

  always_comb begin
    state_next    = state;
    place_wr      = '0;
    case (state)
      odx_pkg::T_IDLE: ;
      odx_pkg::T_INIT: begin
        place_wr.en   = 1'b1;
        place_wr.addr = '0;
        place_wr.data = odx_pkg::NUM_W'(1);
        state_next    = odx_pkg::T_ONE;
      end
      odx_pkg::T_ONE: begin
        place_wr.en   = (a_one != '0);
        place_wr.addr = odx_pkg::PLACE_AW'(1);
        place_wr.data = odx_pkg::NUM_W'(a_one);
        state_next    = (a_one == '0) ? odx_pkg::T_IDLE : odx_pkg::T_MUL;
      end
      odx_pkg::T_MUL: begin
        state_next = (a_k == '0) ? odx_pkg::T_IDLE : odx_pkg::T_ADD;
      end
      odx_pkg::T_ADD: begin
        place_wr.addr = idx;
        place_wr.data = sum[odx_pkg::NUM_W-1:0];
        if (prod > {{odx_pkg::DIGIT_W{1'b0}}, odx_pkg::VAL_LIMIT} || sum[odx_pkg::NUM_W]) begin
          state_next = odx_pkg::T_IDLE;
        end else begin
          place_wr.en = 1'b1;
          state_next  = (idx == odx_pkg::PLACE_AW'(odx_pkg::NUM_PLACES - 1)) ?
                        odx_pkg::T_IDLE : odx_pkg::T_MUL;
        end
      end
      default: state_next = odx_pkg::T_IDLE;
    endcase
    // restart the build after any register write
    if (cfg_wr) begin
      state_next = odx_pkg::T_INIT;
      place_wr   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err <= odx_pkg::ERR_OK;
    end else if (!cfg_wr) begin
      case (state)
        odx_pkg::T_INIT: err <= odx_pkg::ERR_OK;
        odx_pkg::T_ONE:  if (a_one == '0) err <= odx_pkg::ERR_ZERO_QUOT;
        odx_pkg::T_MUL:  if (a_k == '0) err <= odx_pkg::ERR_ZERO_QUOT;
        odx_pkg::T_ADD:
          if (prod > {{odx_pkg::DIGIT_W{1'b0}}, odx_pkg::VAL_LIMIT} || sum[odx_pkg::NUM_W])
            err <= odx_pkg::ERR_OVERFLOW;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      odx_pkg::T_INIT: prev2 <= odx_pkg::NUM_W'(1);
      odx_pkg::T_ONE: begin
        prev <= odx_pkg::NUM_W'(a_one);
        idx  <= odx_pkg::PLACE_AW'(2);
        k    <= KW'(2);
      end
      odx_pkg::T_MUL: begin
        prod <= a_k * prev;
        k    <= kk + KW'(1);
      end
      odx_pkg::T_ADD: begin
        prev2 <= prev;
        prev  <= sum[odx_pkg::NUM_W-1:0];
        idx   <= idx + odx_pkg::PLACE_AW'(1);
        if (idx == odx_pkg::PLACE_AW'(odx_pkg::NUM_PLACES - 1)) top <= sum[odx_pkg::NUM_W-1:0];
      end
      default: ;
    endcase
  end

  assign status.busy = (state != odx_pkg::T_IDLE);
  assign status.err  = err;
  assign status.top  = top;

endmodule

>>> src/odx_front.sv
// Front end: accepts numbers and classifies them into jobs for the queue.
module odx_front (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,
  input  odx_pkg::tbl_status_t          status,
  input  logic                          q_full,
  output logic                          push,
  output odx_pkg::job_t                 job
);

  logic [odx_pkg::NUM_W-1:0] n;

  assign n        = s_tdata[odx_pkg::NUM_W-1:0];
  assign s_tready = !status.busy && !q_full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    job.number = n;
    job.single = 1'b1;
    job.code   = odx_pkg::ERR_OK;
    if (status.err != odx_pkg::ERR_OK) job.code = status.err;
    else if (n >= status.top) job.code = odx_pkg::ERR_RANGE;
    else if (n != '0) job.single = 1'b0;
  end

endmodule

>>> src/odx_queue.sv
// Short job queue between the front end and the digit engine.
module odx_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  odx_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output odx_pkg::job_t head
);

  odx_pkg::job_t                  slots [odx_pkg::QUEUE_DEPTH];
  logic [odx_pkg::QUEUE_AW-1:0]   wr_ptr, rd_ptr;
  logic [odx_pkg::QUEUE_AW:0]     count;

  assign full  = (count == (odx_pkg::QUEUE_AW+1)'(odx_pkg::QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + odx_pkg::QUEUE_AW'(1);
      if (pop) rd_ptr <= rd_ptr + odx_pkg::QUEUE_AW'(1);
      if (push && !pop) count <= count + (odx_pkg::QUEUE_AW+1)'(1);
      else if (pop && !push) count <= count - (odx_pkg::QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule

>>> src/odx_back.sv
// Digit engine: place-value memory and greedy compare-subtract digit search.
module odx_back (
  input  logic                 clk,
  input  logic                 rst,
  input  odx_pkg::place_wr_t   place_wr,
  input  logic                 q_valid,
  input  odx_pkg::job_t        q_head,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,
  output logic                 m_tlast,
  output logic [1:0]           m_tuser
);

  localparam int XW = odx_pkg::NUM_W + odx_pkg::DIGIT_W - 1;

  logic [odx_pkg::NUM_W-1:0]      places [odx_pkg::NUM_PLACES];
  logic [odx_pkg::NUM_W-1:0]      rdata, rem;
  logic [odx_pkg::PLACE_AW-1:0]   idx;
  logic [odx_pkg::DIGIT_W-1:0]    c;
  logic [odx_pkg::DIV_STEP_W-1:0] b;
  logic                           leading, single;
  odx_pkg::err_t                  code;
  odx_pkg::back_state_t           state, state_next;
  logic [XW-1:0]                  shifted;
  logic                           fits, out_free, skip, load;

  always_ff @(posedge clk) begin
    if (place_wr.en) places[place_wr.addr] <= place_wr.data;
    rdata <= places[idx];
  end

  assign shifted  = {{(XW-odx_pkg::NUM_W){1'b0}}, rdata} << b;
  assign fits     = shifted <= {{(XW-odx_pkg::NUM_W){1'b0}}, rem};
  assign out_free = !m_tvalid || m_tready;
  assign skip     = !single && leading && (c == '0);

  always_ff @(posedge clk) begin
    if (rst) state <= odx_pkg::B_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load       = 1'b0;
    case (state)
      odx_pkg::B_IDLE:
        if (q_valid) begin
          pop        = 1'b1;
          state_next = q_head.single ? odx_pkg::B_PUT : odx_pkg::B_READ;
        end
      odx_pkg::B_READ: state_next = odx_pkg::B_DIV;
      odx_pkg::B_DIV:
        if (b == '0) state_next = odx_pkg::B_PUT;
      odx_pkg::B_PUT:
        if (skip) begin
          state_next = odx_pkg::B_READ;
        end else if (out_free) begin
          load       = 1'b1;
          state_next = (single || idx == '0) ? odx_pkg::B_IDLE : odx_pkg::B_READ;
        end
      default: state_next = odx_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      odx_pkg::B_IDLE:
        if (q_valid) begin
          rem     <= q_head.number;
          single  <= q_head.single;
          code    <= q_head.code;
          leading <= 1'b1;
          c       <= '0;
          idx     <= odx_pkg::PLACE_AW'(odx_pkg::NUM_PLACES - 2);
        end
      odx_pkg::B_READ: begin
        c <= '0;
        b <= odx_pkg::DIV_STEP_W'(odx_pkg::DIGIT_W - 1);
      end
      odx_pkg::B_DIV: begin
        // restoring division, one quotient bit per cycle
        if (fits) begin
          rem  <= rem - shifted[odx_pkg::NUM_W-1:0];
          c[b] <= 1'b1;
        end
        b <= b - odx_pkg::DIV_STEP_W'(1);
      end
      odx_pkg::B_PUT:
        if (skip || (load && !single && idx != '0)) begin
          idx <= idx - odx_pkg::PLACE_AW'(1);
          if (load) leading <= 1'b0;
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= c;
      m_tlast <= single || (idx == '0);
      m_tuser <= code;
    end
  end

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != odx_pkg::ERR_OK) |-> m_tlast)
    else $error("error result not marked last");

  a_digit_found: assert property (@(posedge clk) disable iff (rst)
    (state == odx_pkg::B_PUT) && skip |-> idx != '0)
    else $error("nonzero number produced no digit");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

>>> src/ostrowski_digit_expansion.sv
// Top level of the Ostrowski digit expansion block.
//
// Usage: after reset, and after each configuration write, the block builds a
// table of up to 50 place values from the partial quotients, one multiply step
// and one add/check step per place above 1; s_tready stays low meanwhile.
// Input channel s_*: one 63-bit number per request. Output channel m_*: one
// request per digit, most significant first, tlast on the final digit, tuser
// the error code. Errors and zero yield a single digit 0 with tlast.
// Each place, leading zero places too, takes a memory read, 8 compare-subtract
// steps and an output step; a single result goes straight to the output step.
// The digit search of the back end sets the pace. A 4-entry queue holds
// classified numbers so the input side keeps accepting while digits drain.
// A stalled receiver holds the output register; the back end waits, then the
// queue fills and s_tready drops. Reset clears the queue and output, and
// restores the default quotients (Fibonacci place values).
module ostrowski_digit_expansion (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [62:0] number
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] digit
  output logic        m_tlast,
  output logic [1:0]  m_tuser,   // [1:0] error_code
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  odx_pkg::tbl_status_t status;
  odx_pkg::place_wr_t   place_wr;
  odx_pkg::job_t        push_job, head;
  logic                 push, full, pop, q_valid;

  odx_table u_table (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .status, .place_wr
  );

  odx_front u_front (
    .s_tvalid, .s_tready, .s_tdata, .status,
    .q_full(full), .push, .job(push_job)
  );

  odx_queue u_queue (
    .clk, .rst, .push, .push_job, .full, .pop, .valid(q_valid), .head
  );

  odx_back u_back (
    .clk, .rst, .place_wr, .q_valid, .q_head(head), .pop,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
  );

endmodule

>>> tb/sv/odx_checker.sv
// Checker for the Ostrowski digit expansion block: table prediction and digit stream compare.
module odx_checker
  import odx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tlast,
  input  logic [1:0]  m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int          fails,
  output int          pending,
  output logic [63:0] top_place
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] digit;
    logic       last;
    err_t       code;
  } digit_t;

  logic [63:0] qword [4];
  logic [5:0]  seq_len;
  logic [4:0]  rep_idx;
  logic [63:0] places [NUM_PLACES];
  err_t        build_err;
  digit_t      digits_due [$];

  assign pending   = digits_due.size();
  assign top_place = places[NUM_PLACES-1];

  function automatic logic [7:0] quotient(int k);
    return qword[k[4:3]][k[2:0]*8 +: 8];
  endfunction

  function automatic void build_places();
    int len, rep, k;
    logic [63:0] a, prod;
    len = seq_len;
    rep = rep_idx;
    if (len < 2) len = 2;
    if (len > MAX_QUOTIENTS) len = MAX_QUOTIENTS;
    if (rep >= len) rep = len - 1;
    foreach (places[i]) places[i] = '0;
    build_err = ERR_OK;
    places[0] = 64'd1;
    places[1] = quotient(1);
    if (places[1] == 0) begin
      build_err = ERR_ZERO_QUOT;
      return;
    end
    k = 2;
    for (int i = 2; i < NUM_PLACES; i++) begin
      if (k >= len) k = rep;
      a = quotient(k);
      if (a == 0) begin
        build_err = ERR_ZERO_QUOT;
        return;
      end
      if (places[i-1] > VAL_LIMIT / a) begin
        build_err = ERR_OVERFLOW;
        return;
      end
      prod = a * places[i-1];
      if (prod > VAL_LIMIT - places[i-2]) begin
        build_err = ERR_OVERFLOW;
        return;
      end
      places[i] = prod + places[i-2];
      k++;
    end
  endfunction

  function automatic void expand_number(logic [62:0] num);
    logic [63:0] n, c;
    bit leading;
    digit_t d;
    int first;
    n = {1'b0, num};
    leading = 1;
    if (build_err != ERR_OK || n >= places[NUM_PLACES-1]) begin
      d.digit = '0;
      d.last  = 1'b1;
      d.code  = (build_err != ERR_OK) ? build_err : ERR_RANGE;
      digits_due = {digits_due, d};
      return;
    end
    if (n == 0) begin
      d.digit = '0;
      d.last  = 1'b1;
      d.code  = ERR_OK;
      digits_due = {digits_due, d};
      return;
    end
    first = digits_due.size();
    for (int i = NUM_PLACES - 2; i >= 0; i--) begin
      c = (places[i] != 0) ? n / places[i] : 0;
      if (c == 0 && leading) continue;
      if (c > 0) begin
        n -= c * places[i];
        leading = 0;
      end
      d.digit = c[7:0];
      d.last  = 1'b0;
      d.code  = ERR_OK;
      digits_due = {digits_due, d};
    end
    if (digits_due.size() > first) digits_due[$].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    digit_t e;
    if (rst) begin
      qword[0] = QUOT_RESET[63:0];
      qword[1] = QUOT_RESET[127:64];
      qword[2] = QUOT_RESET[191:128];
      qword[3] = QUOT_RESET[255:192];
      seq_len  = 6'd2;
      rep_idx  = 5'd1;
      build_places();
      digits_due.delete();
      fails = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_QWORD_0: qword[0] = cfg_data;
          CFG_QWORD_1: qword[1] = cfg_data;
          CFG_QWORD_2: qword[2] = cfg_data;
          CFG_QWORD_3: qword[3] = cfg_data;
          CFG_SEQ_LEN: seq_len = cfg_data[5:0];
          CFG_REP_IDX: rep_idx = cfg_data[4:0];
          default: ;
        endcase
        build_places();
      end
      if (s_tvalid && s_tready) expand_number(s_tdata[62:0]);
      if (m_tvalid && m_tready) begin
        if (digits_due.size() == 0) begin
          $error("unexpected digit %0d (last %0b, code %0d)", m_tdata, m_tlast, m_tuser);
          fails++;
        end else begin
          e = digits_due.pop_front();
          if (m_tdata !== e.digit) begin
            $error("digit: expected %0d, got %0d", e.digit, m_tdata);
            fails++;
          end
          if (m_tlast !== e.last) begin
            $error("last_digit: expected %0b, got %0b", e.last, m_tlast);
            fails++;
          end
          if (m_tuser !== e.code) begin
            $error("error_code: expected %0d, got %0d", e.code, m_tuser);
            fails++;
          end
        end
      end
    end
  end

endmodule

>>> tb/sv/ostrowski_digit_expansion_tb.sv
// Stimulus and verdict for the Ostrowski digit expansion block.
module ostrowski_digit_expansion_tb;
  import odx_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic        clk;
  logic        rst;
  logic        s_tvalid, s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  int          fails, pending;
  logic [63:0] top_place;
  bit          calm;
  int          quiet_cycles;

  ostrowski_digit_expansion u_dut (.*);

  odx_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stall bursts until the calm tail.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm || $urandom_range(0, 3) != 0) m_tready = 1'b1;
      else begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end
    end
  end

  // Watchdog: count cycles with no request moving on any channel.
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
        quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ostrowski_digit_expansion regression: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Start at a falling edge; a next call keeps valid high if no pause is drawn.
  task automatic send_number(logic [62:0] n);
    s_tvalid = 1'b1;
    s_tdata  = {1'b0, n};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 1'b0;
    if (!calm && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 9)) @(negedge clk);
  endtask

  // Hold until every digit has drained, then let the block settle.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [62:0] pick_number();
    logic [63:0] r;
    int w;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return r[62:0];
      1: return top_place[62:0] - 63'($urandom_range(0, 3)) - 63'd1;
      2: return top_place[62:0] + 63'($urandom_range(0, 3));
      3: return 63'($urandom_range(0, 20));
      default: begin
        w = $urandom_range(1, 63);
        return r[62:0] & ((63'd1 << w) - 63'd1);
      end
    endcase
  endfunction

  task automatic run_batch(int count);
    send_number(63'd0);
    send_number(63'd1);
    send_number(63'd2);
    send_number({63{1'b1}});
    send_number(top_place[62:0] - 63'd1);
    send_number(top_place[62:0]);
    repeat (count) send_number(pick_number());
    drain();
  endtask

  function automatic logic [63:0] small_quotients(int hi);
    logic [63:0] v;
    for (int j = 0; j < 8; j++) v[j*8 +: 8] = 8'($urandom_range(1, hi));
    return v;
  endfunction

  initial begin
    calm      = 0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_QWORD_0;
    cfg_data  = '0;
    rst       = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fibonacci place values from reset.
    run_batch(50);

    // Largest quotients everywhere: place overflow.
    write_reg(CFG_QWORD_0, {64{1'b1}});
    write_reg(CFG_QWORD_1, {64{1'b1}});
    write_reg(CFG_QWORD_2, {64{1'b1}});
    write_reg(CFG_QWORD_3, {64{1'b1}});
    write_reg(CFG_SEQ_LEN, 64'd32);
    write_reg(CFG_REP_IDX, 64'd31);
    run_batch(10);

    // Zero quotient a_1.
    write_reg(CFG_QWORD_0, 64'h0101_0101_0101_0002);
    run_batch(8);

    // Zero quotient later in the sequence.
    write_reg(CFG_QWORD_0, 64'h0101_0101_0101_0102);
    write_reg(CFG_QWORD_1, 64'h0101_0000_0101_0101);
    write_reg(CFG_QWORD_2, 64'h0101_0101_0101_0101);
    write_reg(CFG_QWORD_3, 64'h0101_0101_0101_0101);
    run_batch(8);

    // Length above range clamps to 32; repeat index at its top.
    write_reg(CFG_QWORD_1, small_quotients(2));
    write_reg(CFG_SEQ_LEN, 64'd63);
    write_reg(CFG_REP_IDX, 64'd31);
    run_batch(60);

    // Length below range clamps to 2; repeat index 0 uses a_0.
    write_reg(CFG_QWORD_0, 64'h0101_0101_0101_0302);
    write_reg(CFG_SEQ_LEN, 64'd0);
    write_reg(CFG_REP_IDX, 64'd0);
    run_batch(60);

    // Random small quotients, lengths and repeat points.
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_QWORD_0, small_quotients(3));
      write_reg(CFG_QWORD_1, small_quotients(3));
      write_reg(CFG_QWORD_2, small_quotients(2));
      write_reg(CFG_QWORD_3, small_quotients(2));
      write_reg(CFG_SEQ_LEN, 64'($urandom_range(2, 32)));
      write_reg(CFG_REP_IDX, 64'($urandom_range(0, 31)));
      run_batch(45);
    end

    // Tail without idling on the default Fibonacci table.
    write_reg(CFG_QWORD_0, 64'd72340172838076672);
    write_reg(CFG_QWORD_1, 64'd72340172838076673);
    write_reg(CFG_QWORD_2, 64'd72340172838076673);
    write_reg(CFG_QWORD_3, 64'd72340172838076673);
    write_reg(CFG_SEQ_LEN, 64'd2);
    write_reg(CFG_REP_IDX, 64'd1);
    calm = 1;
    run_batch(40);

    repeat (600) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("ostrowski_digit_expansion regression: pass");
    end else begin
      $display("ostrowski_digit_expansion regression: fail");
    end
    $finish;
  end

endmodule
